@@ design/slpd_pkg.sv @@
// Shared types and constants for the sound level to PWM duty block.
// Used by the top level, the level pipeline and the port checker. No dependencies.
package slpd_pkg;

   localparam int SAMPLE_W    = 12;
   localparam int LEVEL_W     = 12;
   localparam int DUTY_W      = 16;
   localparam int GAIN_W      = 6;
   localparam int REQ_W       = 16;
   localparam int RSP_W       = 32;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_NOISE_FLOOR = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_CAP   = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN        = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DUTY_MAX    = 8'd3;

   localparam logic [LEVEL_W-1:0] NOISE_FLOOR_RESET = 12'd5;
   localparam logic [LEVEL_W-1:0] LEVEL_CAP_RESET   = 12'd200;
   localparam logic [GAIN_W-1:0]  GAIN_RESET        = 6'd5;
   localparam logic [DUTY_W-1:0]  DUTY_MAX_RESET    = 16'd999;

   typedef struct packed {
      logic [LEVEL_W-1:0] noise_floor;
      logic [LEVEL_W-1:0] level_cap;
      logic [GAIN_W-1:0]  gain;
      logic [DUTY_W-1:0]  duty_max;
   } cfg_type;

endpackage

@@ design/sound_level_to_pwm_duty_top.sv @@
// Sound level meter top: calibration, baseline divide, deviation accumulation, CSRs.
// Depends on slpd_pkg and slpd_level_pipe.
//
// Takes one sample per cycle while req_tready is high. After reset the first
// CAL_SAMPLES requests build the baseline and give no response; after the last of
// them req_tready drops while the baseline divide (reciprocal multiply, then one
// correction step) completes. From then on each sample is accumulated in its accept
// cycle and every BLOCK_SAMPLES-th one sends the block sum into a five-register
// pipeline (v1 to v4, then the output register) that gives the response. The input
// then stalls only when that pipeline is full behind a held response.
// CSR writes are taken in any cycle and should be made only while the block is idle.
module sound_level_to_pwm_duty_top
   import slpd_pkg::*;
#(
   parameter int CAL_SAMPLES   = 200,
   parameter int BLOCK_SAMPLES = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_W-1:0]       req_tdata,   // [11:0] sample, [15:12] zero
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_W-1:0]       rsp_tdata,   // [11:0] level, [27:12] duty, [31:28] zero
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int               CW      = $clog2(CAL_SAMPLES + 1);
   localparam int               CSW     = $clog2(CAL_SAMPLES * 4096);
   localparam int               BW      = $clog2(BLOCK_SAMPLES);
   localparam int               BSW     = $clog2(BLOCK_SAMPLES * 4096);
   localparam int               DPW     = 2 * CSW + 1;
   localparam logic [CSW:0]     RECIP_C = (CSW + 1)'((2 ** CSW) / CAL_SAMPLES);
   localparam logic [CSW-1:0]   DIV_C   = CSW'(CAL_SAMPLES);
   localparam logic [CW-1:0]    CAL_LAST   = CW'(CAL_SAMPLES - 1);
   localparam logic [BW-1:0]    BLOCK_LAST = BW'(BLOCK_SAMPLES - 1);

   typedef enum logic [3:0] {
      S_CAL = 4'b0001,
      S_MUL = 4'b0010,
      S_FIX = 4'b0100,
      S_RUN = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   cfg_type               cfg_ff;
   logic [CW-1:0]         cal_count_ff, cal_count_in;
   logic [CSW-1:0]        cal_sum_ff, cal_sum_in;
   logic [DPW-1:0]        div_prod_ff;
   logic [SAMPLE_W-1:0]   baseline_ff;
   logic [SAMPLE_W-1:0]   quot;
   logic [CSW-1:0]        rem;
   logic [BW-1:0]         block_count_ff, block_count_in;
   logic [BSW-1:0]        block_sum_ff, block_sum_in;
   logic [BSW-1:0]        block_total;
   logic [SAMPLE_W-1:0]   sample;
   logic [SAMPLE_W-1:0]   dev;
   logic                  accept;
   logic                  pipe_ready;
   logic                  pipe_valid;
   logic [LEVEL_W-1:0]    rsp_level;
   logic [DUTY_W-1:0]     rsp_duty;

   assign sample      = req_tdata[SAMPLE_W-1:0];
   assign req_tready  = (state_ff == S_CAL) || ((state_ff == S_RUN) && pipe_ready);
   assign accept      = req_tvalid && req_tready;
   assign dev         = (sample > baseline_ff) ? sample - baseline_ff : baseline_ff - sample;
   assign block_total = block_sum_ff + BSW'(dev);
   assign pipe_valid  = accept && (state_ff == S_RUN) && (block_count_ff == BLOCK_LAST);

   assign quot = div_prod_ff[CSW +: SAMPLE_W];
   assign rem  = cal_sum_ff - CSW'(CSW'(quot) * DIV_C);

   always_comb begin
      state_in       = state_ff;
      cal_count_in   = cal_count_ff;
      cal_sum_in     = cal_sum_ff;
      block_count_in = block_count_ff;
      block_sum_in   = block_sum_ff;
      unique case (state_ff)
         S_CAL: begin
            if (accept) begin
               cal_sum_in = cal_sum_ff + CSW'(sample);
               if (cal_count_ff == CAL_LAST) begin
                  state_in = S_MUL;
               end else begin
                  cal_count_in = cal_count_ff + 1'b1;
               end
            end
         end
         S_MUL: begin
            state_in = S_FIX;
         end
         S_FIX: begin
            state_in = S_RUN;
         end
         S_RUN: begin
            if (accept) begin
               if (block_count_ff == BLOCK_LAST) begin
                  block_count_in = '0;
                  block_sum_in   = '0;
               end else begin
                  block_count_in = block_count_ff + 1'b1;
                  block_sum_in   = block_total;
               end
            end
         end
         default: begin
            state_in = S_CAL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CAL;
         cal_count_ff   <= '0;
         cal_sum_ff     <= '0;
         block_count_ff <= '0;
         block_sum_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         cal_count_ff   <= cal_count_in;
         cal_sum_ff     <= cal_sum_in;
         block_count_ff <= block_count_in;
         block_sum_ff   <= block_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_MUL) begin
         div_prod_ff <= DPW'(cal_sum_ff) * DPW'(RECIP_C);
      end
      if (state_ff == S_FIX) begin
         baseline_ff <= (rem >= DIV_C) ? quot + 1'b1 : quot;
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.noise_floor <= NOISE_FLOOR_RESET;
         cfg_ff.level_cap   <= LEVEL_CAP_RESET;
         cfg_ff.gain        <= GAIN_RESET;
         cfg_ff.duty_max    <= DUTY_MAX_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NOISE_FLOOR: cfg_ff.noise_floor <= csr_data[LEVEL_W-1:0];
            CSR_LEVEL_CAP:   cfg_ff.level_cap   <= csr_data[LEVEL_W-1:0];
            CSR_GAIN:        cfg_ff.gain        <= csr_data[GAIN_W-1:0];
            CSR_DUTY_MAX:    cfg_ff.duty_max    <= csr_data[DUTY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   slpd_level_pipe #(
      .BLOCK_SAMPLES (BLOCK_SAMPLES)
   ) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .sum_valid (pipe_valid),
      .sum_ready (pipe_ready),
      .sum       (block_total),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_level (rsp_level),
      .rsp_duty  (rsp_duty)
   );

   assign rsp_tdata = {(RSP_W - LEVEL_W - DUTY_W)'(0), rsp_duty, rsp_level};

endmodule

@@ design/slpd_level_pipe.sv @@
// Block-end pipeline: mean of the deviation sum, floor gate, cap, gain and saturation.
// Depends on slpd_pkg for the register set type and field widths.
module slpd_level_pipe
   import slpd_pkg::*;
#(
   parameter int BLOCK_SAMPLES = 32,
   parameter int SUM_W         = $clog2(BLOCK_SAMPLES * 4096)
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                sum_valid,
   output logic                sum_ready,
   input  logic [SUM_W-1:0]    sum,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [LEVEL_W-1:0]  rsp_level,
   output logic [DUTY_W-1:0]   rsp_duty
);

   localparam int                PROD_W  = 2 * SUM_W + 1;
   localparam logic [SUM_W:0]    RECIP_B = (SUM_W + 1)'((2 ** SUM_W) / BLOCK_SAMPLES);
   localparam logic [SUM_W-1:0]  DIV_B   = SUM_W'(BLOCK_SAMPLES);
   localparam int                MUL_W   = LEVEL_W + GAIN_W;

   logic                 v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic                 free1, free2, free3, free4, free_out;

   logic [SUM_W-1:0]     sum1_ff;
   logic [SUM_W-1:0]     sum2_ff;
   logic [PROD_W-1:0]    prod2_ff;
   logic [PROD_W-1:0]    prod2_in;
   logic [LEVEL_W-1:0]   level3_ff;
   logic [LEVEL_W-1:0]   level3_in;
   logic [LEVEL_W-1:0]   level4_ff;
   logic                 below4_ff;
   logic [MUL_W-1:0]     mul4_ff;
   logic [MUL_W-1:0]     mul4_in;
   logic [LEVEL_W-1:0]   clamped;
   logic [LEVEL_W-1:0]   quot;
   logic [SUM_W-1:0]     rem;
   logic [LEVEL_W-1:0]   level_out_ff;
   logic [DUTY_W-1:0]    duty_out_ff;
   logic [DUTY_W-1:0]    duty_in;

   assign free_out  = !rsp_valid_ff || rsp_ready;
   assign free4     = !v4_ff || free_out;
   assign free3     = !v3_ff || free4;
   assign free2     = !v2_ff || free3;
   assign free1     = !v1_ff || free2;
   assign sum_ready = free1;

   assign prod2_in  = PROD_W'(sum1_ff) * PROD_W'(RECIP_B);
   assign quot      = prod2_ff[SUM_W +: LEVEL_W];
   assign rem       = sum2_ff - SUM_W'(SUM_W'(quot) * DIV_B);
   assign level3_in = (rem >= DIV_B) ? quot + 1'b1 : quot;

   assign clamped   = (level3_ff > cfg.level_cap) ? cfg.level_cap : level3_ff;
   assign mul4_in   = MUL_W'(clamped) * MUL_W'(cfg.gain);

   always_comb begin
      if (below4_ff) begin
         duty_in = '0;
      end else if (mul4_ff > MUL_W'(cfg.duty_max)) begin
         duty_in = cfg.duty_max;
      end else begin
         duty_in = DUTY_W'(mul4_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (free1)    v1_ff        <= sum_valid;
         if (free2)    v2_ff        <= v1_ff;
         if (free3)    v3_ff        <= v2_ff;
         if (free4)    v4_ff        <= v3_ff;
         if (free_out) rsp_valid_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (free1 && sum_valid) begin
         sum1_ff <= sum;
      end
      if (free2 && v1_ff) begin
         prod2_ff <= prod2_in;
         sum2_ff  <= sum1_ff;
      end
      if (free3 && v2_ff) begin
         level3_ff <= level3_in;
      end
      if (free4 && v3_ff) begin
         level4_ff <= level3_ff;
         below4_ff <= level3_ff < cfg.noise_floor;
         mul4_ff   <= mul4_in;
      end
      if (free_out && v4_ff) begin
         level_out_ff <= level4_ff;
         duty_out_ff  <= duty_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = level_out_ff;
   assign rsp_duty  = duty_out_ff;

endmodule

@@ design/slpd_checker.sv @@
// Port-level checks for the sound level to PWM duty top, attached by bind.
// Depends on slpd_pkg for the response width.
module slpd_checker
   import slpd_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("held response changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_ready_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_tready)
      else $error("request not taken at start of calibration");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_W-1:28] == '0)
      else $error("response padding not zero");

endmodule

bind sound_level_to_pwm_duty_top slpd_checker u_slpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
